>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain condition checked on every clock edge outside reset
`define AST_CLK(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Same-cycle implication checked on every clock edge outside reset
`define AST_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> sv/hbt_pkg.sv
// ---------------------------------------------------------------------------
// hbt_pkg
// Types and codes for the handshake bus transmitter.
// ---------------------------------------------------------------------------
`default_nettype none

package hbt_pkg;

   // item operations
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_LOAD = 2'd1;
   localparam logic [1:0] OP_SEND = 2'd2;

   // send result codes
   localparam logic [1:0] ERR_OK     = 2'd0;
   localparam logic [1:0] ERR_BUS    = 2'd1;
   localparam logic [1:0] ERR_STROBE = 2'd2;

   // transfer phases
   localparam logic [2:0] PH_IDLE        = 3'd0;
   localparam logic [2:0] PH_WAIT_BUS    = 3'd1;
   localparam logic [2:0] PH_WAIT_STROBE = 3'd2;
   localparam logic [2:0] PH_START_PAUSE = 3'd3;
   localparam logic [2:0] PH_BIT_SETUP   = 3'd4;
   localparam logic [2:0] PH_BIT_LOW     = 3'd5;
   localparam logic [2:0] PH_BYTE_PAUSE  = 3'd6;

   // configuration register indexes
   localparam logic [2:0] CSR_BUS_TICKS    = 3'd0;
   localparam logic [2:0] CSR_BUS_LOOPS    = 3'd1;
   localparam logic [2:0] CSR_STROBE_TICKS = 3'd2;
   localparam logic [2:0] CSR_STROBE_LOOPS = 3'd3;
   localparam logic [2:0] CSR_START_PAUSE  = 3'd4;
   localparam logic [2:0] CSR_BIT_PAUSE    = 3'd5;
   localparam logic [2:0] CSR_BYTE_PAUSE   = 3'd6;

   // result item, lowest bit last in the list
   typedef struct packed {
      logic [5:0] pad;
      logic [1:0] error_code;
      logic       done_res;
      logic       busy_res;
      logic       rx_irq_enable;
      logic       clk_out;
      logic       clk_drive;
      logic       act_drive;
      logic       dat_out;
      logic       dat_drive;
   } rsp_fields_type;

endpackage

`default_nettype wire

>>> sv/handshake_bus_transmitter_core.sv
// ---------------------------------------------------------------------------
// handshake_bus_transmitter_core
// Sends a buffered message over a three-wire handshake bus, one tick or
// pin sample per item.
// ---------------------------------------------------------------------------
// Channel  Direction  Handshake                Payload
// req      in         req_tvalid / req_tready  tuser operation, tdata byte+levels
// rsp      out        rsp_tvalid / rsp_tready  tdata line drives and status
// csr      in         csr_valid / csr_ready    csr_index, csr_data
//
// One item is taken per clock, rsp permitting; its result item is registered
// and shows in the cycle after acceptance. req_tready is low only while a
// result waits unclaimed: a stalled rsp side holds req off and nothing else.
// Reset is synchronous; the message store has no reset and needs no sweep.
// The message byte is read from a registered store port one byte ahead.
// ---------------------------------------------------------------------------
`default_nettype none

module handshake_bus_transmitter_core #(
   parameter int MSG_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // [1:0] operation
   input  wire logic [15:0] req_tdata,   // [7:0] byte_value, [8] act_level, [9] clk_level
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [0] dat_drive, [1] dat_out, [2] act_drive,
                                         // [3] clk_drive, [4] clk_out, [5] rx_irq_enable,
                                         // [6] busy_res, [7] done_res, [9:8] error_code
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import hbt_pkg::*;

   localparam int IDX_W  = $clog2(MSG_DEPTH + 1);
   localparam int ADDR_W = $clog2(MSG_DEPTH);
   localparam logic [8:0]       DepthWide = 9'(MSG_DEPTH);
   localparam logic [IDX_W-1:0] DepthIdx  = IDX_W'(MSG_DEPTH);

   // configuration registers
   logic [15:0] bus_ticks_ff, strobe_ticks_ff, start_pause_ff, bit_pause_ff, byte_pause_ff;
   logic [7:0]  bus_loops_ff, strobe_loops_ff;

   // transfer state
   logic [2:0]        phase_ff, phase_in;
   logic [IDX_W-1:0]  load_ptr_ff, load_ptr_in;
   logic [IDX_W-1:0]  byte_idx_ff, byte_idx_in;
   logic [2:0]        bit_idx_ff, bit_idx_in;
   logic [15:0]       tick_ff, tick_in;
   logic [7:0]        loop_ff, loop_in;
   logic [IDX_W-1:0]  len_ff;
   logic [7:0]        cur_byte_ff, cur_byte_in;
   logic              dat_drive_ff, dat_drive_in, dat_level_ff, dat_level_in;
   logic              act_drive_ff, act_drive_in;
   logic              clk_drive_ff, clk_drive_in, clk_level_ff, clk_level_in;
   logic              irq_en_ff, irq_en_in;
   logic [1:0]        err_ff, err_in;
   logic              done_in;

   // message store
   logic [7:0]        msg_store_ff [MSG_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [IDX_W-1:0]  rd_idx;
   logic [ADDR_W-1:0] rd_addr;
   logic              mem_we;

   // result register
   rsp_fields_type    rsp_ff, rsp_in;
   logic              rsp_valid_ff;

   // unpacked input item
   logic       req_accept;
   logic [1:0] req_op;
   logic [7:0] req_byte;
   logic       req_act, req_clk;

   // timing helpers
   logic [16:0] tick_inc;
   logic [15:0] wait_ticks, pause_len;
   logic [7:0]  wait_loops;
   logic        period_end, pause_end, loop_hit;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign req_op     = req_tuser;
   assign req_byte   = req_tdata[7:0];
   assign req_act    = req_tdata[8];
   assign req_clk    = req_tdata[9];
   assign csr_ready  = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ticks_ff    <= 16'd20000;
         bus_loops_ff    <= 8'd10;
         strobe_ticks_ff <= 16'hFFFF;
         strobe_loops_ff <= 8'd10;
         start_pause_ff  <= 16'd100;
         bit_pause_ff    <= 16'd50;
         byte_pause_ff   <= 16'd100;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BUS_TICKS:    bus_ticks_ff    <= csr_data;
            CSR_BUS_LOOPS:    bus_loops_ff    <= csr_data[7:0];
            CSR_STROBE_TICKS: strobe_ticks_ff <= csr_data;
            CSR_STROBE_LOOPS: strobe_loops_ff <= csr_data[7:0];
            CSR_START_PAUSE:  start_pause_ff  <= csr_data;
            CSR_BIT_PAUSE:    bit_pause_ff    <= csr_data;
            CSR_BYTE_PAUSE:   byte_pause_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // wait and pause limits for the current phase
   always_comb begin
      wait_ticks = (phase_ff == PH_WAIT_BUS) ? bus_ticks_ff : strobe_ticks_ff;
      wait_loops = (phase_ff == PH_WAIT_BUS) ? bus_loops_ff : strobe_loops_ff;
      case (phase_ff)
         PH_START_PAUSE: pause_len = start_pause_ff;
         PH_BYTE_PAUSE:  pause_len = byte_pause_ff;
         default:        pause_len = bit_pause_ff;
      endcase
   end

   assign tick_inc   = {1'b0, tick_ff} + 17'd1;
   assign period_end = tick_inc >= {1'b0, wait_ticks};
   assign pause_end  = tick_inc >= {1'b0, pause_len};
   assign loop_hit   = loop_ff >= wait_loops;

   // store read runs one byte ahead once bits are on the wire
   always_comb begin
      if (phase_ff == PH_BIT_SETUP || phase_ff == PH_BIT_LOW || phase_ff == PH_BYTE_PAUSE)
         rd_idx = byte_idx_ff + IDX_W'(1);
      else
         rd_idx = byte_idx_ff;
      rd_addr = (rd_idx < DepthIdx) ? rd_idx[ADDR_W-1:0] : '0;
   end

   assign mem_we = req_accept && (phase_ff == PH_IDLE) && (req_op == OP_LOAD)
                   && (load_ptr_ff < DepthIdx);

   always_ff @(posedge clock) begin
      if (mem_we)
         msg_store_ff[load_ptr_ff[ADDR_W-1:0]] <= req_byte;
      rd_data_ff <= msg_store_ff[rd_addr];
   end

   // saturated length taken as the first byte is loaded
   always_ff @(posedge clock) begin
      if (mem_we && load_ptr_ff == '0)
         len_ff <= ({1'b0, req_byte} > DepthWide) ? DepthIdx : req_byte[IDX_W-1:0];
   end

   // next transfer state for the item
   always_comb begin
      phase_in     = phase_ff;
      load_ptr_in  = load_ptr_ff;
      byte_idx_in  = byte_idx_ff;
      bit_idx_in   = bit_idx_ff;
      tick_in      = tick_ff;
      loop_in      = loop_ff;
      cur_byte_in  = cur_byte_ff;
      dat_drive_in = dat_drive_ff;
      dat_level_in = dat_level_ff;
      act_drive_in = act_drive_ff;
      clk_drive_in = clk_drive_ff;
      clk_level_in = clk_level_ff;
      irq_en_in    = irq_en_ff;
      err_in       = err_ff;
      done_in      = 1'b0;

      if (req_accept) begin
         if (phase_ff == PH_IDLE) begin
            if (req_op == OP_LOAD) begin
               if (load_ptr_ff < DepthIdx)
                  load_ptr_in = load_ptr_ff + IDX_W'(1);
            end else if (req_op == OP_SEND) begin
               irq_en_in    = 1'b0;
               dat_drive_in = 1'b0;
               dat_level_in = 1'b0;
               act_drive_in = 1'b0;
               clk_drive_in = 1'b0;
               clk_level_in = 1'b0;
               tick_in      = '0;
               loop_in      = '0;
               byte_idx_in  = '0;
               bit_idx_in   = '0;
               phase_in     = PH_WAIT_BUS;
            end
         end else if (req_op == OP_TICK) begin
            case (phase_ff)
               PH_WAIT_BUS, PH_WAIT_STROBE: begin
                  if (phase_ff == PH_WAIT_BUS && req_act) begin
                     dat_drive_in = 1'b1;
                     act_drive_in = 1'b1;
                     tick_in      = '0;
                     loop_in      = '0;
                     phase_in     = PH_WAIT_STROBE;
                  end else if (phase_ff == PH_WAIT_STROBE && !req_clk) begin
                     dat_level_in = 1'b1;
                     tick_in      = '0;
                     phase_in     = PH_START_PAUSE;
                  end else if (period_end) begin
                     tick_in = '0;
                     if (loop_hit) begin
                        done_in = 1'b1;
                        err_in  = (phase_ff == PH_WAIT_BUS) ? ERR_BUS : ERR_STROBE;
                     end else begin
                        loop_in = loop_ff + 8'd1;
                     end
                  end else begin
                     tick_in = tick_inc[15:0];
                  end
               end
               PH_START_PAUSE, PH_BIT_SETUP, PH_BIT_LOW, PH_BYTE_PAUSE: begin
                  if (!pause_end) begin
                     tick_in = tick_inc[15:0];
                  end else begin
                     tick_in = '0;
                     case (phase_ff)
                        PH_START_PAUSE: begin
                           clk_drive_in = 1'b1;
                           clk_level_in = 1'b1;
                           if (len_ff == '0) begin
                              done_in = 1'b1;
                              err_in  = ERR_OK;
                           end else begin
                              cur_byte_in  = rd_data_ff;
                              dat_level_in = rd_data_ff[0];
                              phase_in     = PH_BIT_SETUP;
                           end
                        end
                        PH_BIT_SETUP: begin
                           clk_level_in = 1'b0;
                           phase_in     = PH_BIT_LOW;
                        end
                        PH_BIT_LOW: begin
                           clk_level_in = 1'b1;
                           bit_idx_in   = bit_idx_ff + 3'd1;
                           if (bit_idx_ff == 3'd7) begin
                              phase_in = PH_BYTE_PAUSE;
                           end else begin
                              dat_level_in = cur_byte_ff[bit_idx_in];
                              phase_in     = PH_BIT_SETUP;
                           end
                        end
                        default: begin
                           // byte pause over: next byte or end of message
                           byte_idx_in = byte_idx_ff + IDX_W'(1);
                           if (byte_idx_in >= len_ff) begin
                              done_in = 1'b1;
                              err_in  = ERR_OK;
                           end else begin
                              cur_byte_in  = rd_data_ff;
                              dat_level_in = rd_data_ff[0];
                              phase_in     = PH_BIT_SETUP;
                           end
                        end
                     endcase
                  end
               end
               default: begin
                  done_in = 1'b1;
                  err_in  = ERR_OK;
               end
            endcase

            // end of send: release the bus and rearm reception
            if (done_in) begin
               dat_drive_in = 1'b0;
               dat_level_in = 1'b0;
               act_drive_in = 1'b0;
               clk_drive_in = 1'b0;
               clk_level_in = 1'b0;
               irq_en_in    = 1'b1;
               phase_in     = PH_IDLE;
               load_ptr_in  = '0;
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         load_ptr_ff  <= '0;
         byte_idx_ff  <= '0;
         bit_idx_ff   <= '0;
         tick_ff      <= '0;
         loop_ff      <= '0;
         dat_drive_ff <= 1'b0;
         dat_level_ff <= 1'b0;
         act_drive_ff <= 1'b0;
         clk_drive_ff <= 1'b0;
         clk_level_ff <= 1'b0;
         irq_en_ff    <= 1'b1;
         err_ff       <= ERR_OK;
      end else begin
         phase_ff     <= phase_in;
         load_ptr_ff  <= load_ptr_in;
         byte_idx_ff  <= byte_idx_in;
         bit_idx_ff   <= bit_idx_in;
         tick_ff      <= tick_in;
         loop_ff      <= loop_in;
         dat_drive_ff <= dat_drive_in;
         dat_level_ff <= dat_level_in;
         act_drive_ff <= act_drive_in;
         clk_drive_ff <= clk_drive_in;
         clk_level_ff <= clk_level_in;
         irq_en_ff    <= irq_en_in;
         err_ff       <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_byte_ff <= cur_byte_in;
   end

   // result item built from the state after the item
   always_comb begin
      rsp_in               = '0;
      rsp_in.dat_drive     = dat_drive_in;
      rsp_in.dat_out       = dat_drive_in && dat_level_in;
      rsp_in.act_drive     = act_drive_in;
      rsp_in.clk_drive     = clk_drive_in;
      rsp_in.clk_out       = clk_drive_in && clk_level_in;
      rsp_in.rx_irq_enable = irq_en_in;
      rsp_in.busy_res      = (phase_in != PH_IDLE);
      rsp_in.done_res      = done_in;
      rsp_in.error_code    = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (req_accept)
         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (req_accept)
         rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // checks
`include "assert_macros.svh"
   `AST_CLK(a_done_not_busy, !(rsp_valid_ff && rsp_ff.done_res && rsp_ff.busy_res), "done while busy")
   `AST_IMP(a_idle_released, phase_ff == PH_IDLE, !dat_drive_ff && !act_drive_ff && !clk_drive_ff && irq_en_ff, "lines held while idle")
   `AST_IMP(a_byte_in_range, phase_ff == PH_BIT_SETUP || phase_ff == PH_BIT_LOW, byte_idx_ff < len_ff, "byte index past length")
   `AST_CLK(a_load_ptr_range, load_ptr_ff <= DepthIdx, "load pointer past store")

endmodule

`default_nettype wire
